### rtl/asa_pkg.sv
// asa_pkg: shared types, widths, command codes and datapath operations
// for the sample averager. No dependencies.
`timescale 1ns / 1ps

package asa_pkg;

   // field and state widths
   localparam int SAMPLE_W   = 10;
   localparam int FRAC_W     = 8;
   localparam int COUNT_W    = 6;
   localparam int SUM_W      = SAMPLE_W + COUNT_W;
   localparam int AVG_W      = 24;
   localparam int MV_W       = 16;
   localparam int VCC_W      = 13;
   localparam int VALUE_W    = 32;
   localparam int PROD_W     = VALUE_W + VCC_W;
   localparam int CMD_W      = 3;

   // shared iterative divider, two quotient bits per cycle
   localparam int DIV_NUM_W  = SUM_W + FRAC_W;
   localparam int DIV_DEN_W  = 16;
   localparam int DIV_STEP_W = $clog2(DIV_NUM_W / 2 + 1);
   localparam int SUP_NUM_W  = 22;

   // ratiometric divide by 2^RAT_FOLD_W - 1, done by folding
   localparam int RAT_FOLD_W = 10;

   // constants
   localparam logic [SUP_NUM_W-1:0]  VCC_NUM    = SUP_NUM_W'(1126400);
   localparam logic [COUNT_W-1:0]    COUNT_WRAP = COUNT_W'(63);
   localparam logic [COUNT_W-1:0]    COUNT_HALF = COUNT_W'(32);
   localparam logic [MV_W-1:0]       VCC_MIN    = MV_W'(4000);
   localparam logic [MV_W-1:0]       VCC_MAX    = MV_W'(6000);
   localparam logic [VCC_W-1:0]      RATIO_MUL  = VCC_W'(5000);
   localparam logic [RAT_FOLD_W-1:0] RATIO_DIV  = RAT_FOLD_W'(1023);
   localparam int                    VCC_SHIFT  = 10;

   // quotient steps (two bits each) per division
   localparam logic [DIV_STEP_W-1:0] AVG_STEPS = DIV_STEP_W'((SUM_W + FRAC_W) / 2);
   localparam logic [DIV_STEP_W-1:0] SUP_STEPS = DIV_STEP_W'(SUP_NUM_W / 2);

   // command codes
   localparam logic [CMD_W-1:0] CMD_SAMPLE      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ_AVG    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ_LATEST = 3'd2;
   localparam logic [CMD_W-1:0] CMD_VOLT_AVG    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_VOLT_LATEST = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RATIO       = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [SAMPLE_W-1:0] sample;
      logic [MV_W-1:0]     supply_mv;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               status;
      logic               fresh;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_SAMPLE,
      OP_KEPT,
      OP_LATEST,
      OP_AVG_START,
      OP_AVG_TAKE,
      OP_SUP_START,
      OP_SUP_TAKE,
      OP_ZERO,
      OP_VCC_MUL,
      OP_RAT_MUL,
      OP_RAT_FOLD,
      OP_RAT_TAKE,
      OP_RESPOND
   } op_type;

   typedef struct packed {
      logic   capture;   // latch supply voltage, clear flags
      op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic n_zero;
      logic supply;
      logic div_done;
      logic fold_done;
      logic out_free;
   } ctl_sts_type;

endpackage

### rtl/asa_divider.sv
// asa_divider: restoring divider, two quotient bits per cycle.
// Numerator comes in aligned at the top; runs for the given step count. Uses asa_pkg.
`timescale 1ns / 1ps

module asa_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [asa_pkg::DIV_NUM_W-1:0]    num,
   input  logic [asa_pkg::DIV_DEN_W-1:0]    den,
   input  logic [asa_pkg::DIV_STEP_W-1:0]   steps,
   output logic                             busy,
   output logic                             done,
   output logic [asa_pkg::DIV_NUM_W-1:0]    quot
);
   import asa_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0]  q_ff, q_in;
   logic [DIV_DEN_W-1:0]  r_ff, r_in;
   logic [DIV_DEN_W-1:0]  d_ff, d_in;

   logic [DIV_DEN_W:0]    t1, t2;
   logic                  ge1, ge2;
   logic [DIV_DEN_W-1:0]  r1, r2;
   logic [DIV_NUM_W-1:0]  q1, q2;

   always_comb begin
      t1  = {r_ff, q_ff[DIV_NUM_W-1]};
      ge1 = (t1 >= {1'b0, d_ff});
      r1  = ge1 ? DIV_DEN_W'(t1 - {1'b0, d_ff}) : t1[DIV_DEN_W-1:0];
      q1  = {q_ff[DIV_NUM_W-2:0], ge1};
      t2  = {r1, q1[DIV_NUM_W-1]};
      ge2 = (t2 >= {1'b0, d_ff});
      r2  = ge2 ? DIV_DEN_W'(t2 - {1'b0, d_ff}) : t2[DIV_DEN_W-1:0];
      q2  = {q1[DIV_NUM_W-2:0], ge2};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         q_in    = num;
         r_in    = '0;
         d_in    = den;
      end else if (busy_ff) begin
         q_in   = q2;
         r_in   = r2;
         cnt_in = cnt_ff - DIV_STEP_W'(1);
         if (cnt_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not go busy after start");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == DIV_STEP_W'(1)) |=> done_ff)
      else $error("divider missed done after last step");

endmodule

### rtl/asa_datapath.sv
// asa_datapath: averager state, working value, multiplier, output register.
// Driven by op codes from asa_controller; uses asa_pkg and asa_divider.
`timescale 1ns / 1ps

module asa_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  asa_pkg::req_type     req_payload,
   input  logic                 csr_valid,
   input  logic                 csr_data,
   input  asa_pkg::ctl_cmd_type cmd,
   output asa_pkg::ctl_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output asa_pkg::rsp_type     rsp_payload
);
   import asa_pkg::*;

   logic                supply_ff, supply_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [AVG_W-1:0]    kept_ff, kept_in;
   logic [SAMPLE_W-1:0] latest_ff, latest_in;
   logic [VCC_W-1:0]    vcc_ff, vcc_in;
   logic [PROD_W-1:0]   val_ff, val_in;
   logic [PROD_W-1:0]   rat_q_ff, rat_q_in;
   logic                zero_ff, zero_in;
   logic                fresh_ff, fresh_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [SUM_W-1:0]             sum_add;
   logic [MV_W-1:0]              mv_clamped;
   logic [VCC_W-1:0]             mul_b;
   logic [PROD_W-1:0]            prod;
   logic [DIV_DEN_W-1:0]         n_val;
   logic [PROD_W-RAT_FOLD_W-1:0] fold_hi;
   logic [RAT_FOLD_W-1:0]        fold_lo;
   logic                         div_start;
   logic [DIV_NUM_W-1:0]         div_num;
   logic [DIV_DEN_W-1:0]         div_den;
   logic [DIV_STEP_W-1:0]        div_steps;
   logic                         div_busy, div_done;
   logic [DIV_NUM_W-1:0]         div_quot;

   assign sum_add = sum_ff + SUM_W'(req_payload.sample);
   assign n_val   = val_ff[FRAC_W +: DIV_DEN_W];
   assign mul_b   = (cmd.op == OP_RAT_MUL) ? RATIO_MUL : vcc_ff;
   assign prod    = PROD_W'(val_ff[VALUE_W-1:0]) * PROD_W'(mul_b);

   // x = 1023*q + r; folding r = a*1024 + b gives q += a, r = a + b
   assign fold_hi = val_ff[PROD_W-1:RAT_FOLD_W];
   assign fold_lo = val_ff[RAT_FOLD_W-1:0];

   always_comb begin
      if (req_payload.supply_mv < VCC_MIN) begin
         mv_clamped = VCC_MIN;
      end else if (req_payload.supply_mv > VCC_MAX) begin
         mv_clamped = VCC_MAX;
      end else begin
         mv_clamped = req_payload.supply_mv;
      end
   end

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      div_steps = '0;
      case (cmd.op)
         OP_AVG_START: begin
            div_start = 1'b1;
            div_num   = {sum_ff, {(DIV_NUM_W-SUM_W){1'b0}}};
            div_den   = DIV_DEN_W'(count_ff);
            div_steps = AVG_STEPS;
         end
         OP_SUP_START: begin
            div_start = 1'b1;
            div_num   = {VCC_NUM, {(DIV_NUM_W-SUP_NUM_W){1'b0}}};
            div_den   = n_val;
            div_steps = SUP_STEPS;
         end
         default: begin
         end
      endcase
   end

   asa_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      supply_in    = csr_valid ? csr_data : supply_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      kept_in      = kept_ff;
      latest_in    = latest_ff;
      vcc_in       = vcc_ff;
      val_in       = val_ff;
      rat_q_in     = rat_q_ff;
      zero_in      = zero_ff;
      fresh_in     = fresh_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.capture) begin
         vcc_in   = VCC_W'(mv_clamped);
         zero_in  = 1'b0;
         fresh_in = 1'b0;
      end

      case (cmd.op)
         OP_SAMPLE: begin
            latest_in = req_payload.sample;
            if (count_ff >= COUNT_WRAP) begin
               sum_in   = sum_add >> 1;
               count_in = COUNT_HALF;
            end else begin
               sum_in   = sum_add;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_KEPT: begin
            val_in = PROD_W'(kept_ff);
         end
         OP_LATEST: begin
            val_in = PROD_W'({latest_ff, {FRAC_W{1'b0}}});
         end
         OP_AVG_TAKE: begin
            kept_in  = div_quot[AVG_W-1:0];
            val_in   = PROD_W'(div_quot[AVG_W-1:0]);
            sum_in   = '0;
            count_in = '0;
            fresh_in = 1'b1;
         end
         OP_SUP_TAKE: begin
            val_in = PROD_W'({div_quot[SUP_NUM_W-1:0], {FRAC_W{1'b0}}});
         end
         OP_ZERO: begin
            val_in  = PROD_W'({VALUE_W{1'b1}});
            zero_in = 1'b1;
         end
         OP_VCC_MUL: begin
            val_in = prod >> VCC_SHIFT;
         end
         OP_RAT_MUL: begin
            val_in   = prod;
            rat_q_in = '0;
         end
         OP_RAT_FOLD: begin
            val_in   = PROD_W'(fold_hi) + PROD_W'(fold_lo);
            rat_q_in = rat_q_ff + PROD_W'(fold_hi);
         end
         OP_RAT_TAKE: begin
            // residue below 1024; exactly 1023 is one more whole quotient
            val_in = rat_q_ff + PROD_W'(fold_lo == RATIO_DIV);
         end
         OP_RESPOND: begin
            rsp_valid_in = 1'b1;
            rsp_in.value = (|val_ff[PROD_W-1:VALUE_W]) ? {VALUE_W{1'b1}}
                                                       : val_ff[VALUE_W-1:0];
            rsp_in.status = zero_ff;
            rsp_in.fresh  = fresh_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff    <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         kept_ff      <= '0;
         latest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         supply_ff    <= supply_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         kept_ff      <= kept_in;
         latest_ff    <= latest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vcc_ff   <= vcc_in;
      val_ff   <= val_in;
      rat_q_ff <= rat_q_in;
      zero_ff  <= zero_in;
      fresh_ff <= fresh_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      sts.count_zero = (count_ff == '0);
      sts.n_zero     = (n_val == '0);
      sts.supply     = supply_ff;
      sts.div_done   = div_done;
      sts.fold_done  = (fold_hi == '0);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_avg_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_AVG_TAKE) |=> (count_ff == '0 && sum_ff == '0))
      else $error("average read did not clear sum and count");

   a_respond_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESPOND) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written over a pending transfer");

   a_sup_divisor: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SUP_START) |-> (n_val != '0))
      else $error("supply division started with zero divisor");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

endmodule

### rtl/asa_controller.sv
// asa_controller: one-hot sequencer that walks a read command through
// average, supply conversion and scaling. Uses asa_pkg.
`timescale 1ns / 1ps

module asa_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [asa_pkg::CMD_W-1:0]    req_command,
   output logic                         req_stall,
   output asa_pkg::ctl_cmd_type         cmd,
   input  asa_pkg::ctl_sts_type         sts
);
   import asa_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b000_0001,
      S_AVG_DIV  = 7'b000_0010,
      S_POST     = 7'b000_0100,
      S_SUP_DIV  = 7'b000_1000,
      S_SCALE    = 7'b001_0000,
      S_RAT_FOLD = 7'b010_0000,
      S_RESP     = 7'b100_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      cmd.capture = 1'b0;
      cmd.op      = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               case (req_command)
                  CMD_SAMPLE: begin
                     cmd.op = OP_SAMPLE;
                  end
                  CMD_READ_AVG, CMD_VOLT_AVG, CMD_RATIO: begin
                     cmd.capture = 1'b1;
                     if (sts.count_zero) begin
                        cmd.op   = OP_KEPT;
                        state_in = S_POST;
                     end else begin
                        cmd.op   = OP_AVG_START;
                        state_in = S_AVG_DIV;
                     end
                  end
                  CMD_READ_LATEST, CMD_VOLT_LATEST: begin
                     cmd.capture = 1'b1;
                     cmd.op      = OP_LATEST;
                     state_in    = S_POST;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_AVG_DIV: begin
            if (sts.div_done) begin
               cmd.op   = OP_AVG_TAKE;
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (!sts.supply) begin
               state_in = S_SCALE;
            end else if (sts.n_zero) begin
               cmd.op   = OP_ZERO;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_SUP_START;
               state_in = S_SUP_DIV;
            end
         end
         S_SUP_DIV: begin
            if (sts.div_done) begin
               cmd.op   = OP_SUP_TAKE;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            state_in = S_RESP;
            case (cmd_ff)
               CMD_VOLT_AVG: begin
                  cmd.op = OP_VCC_MUL;
               end
               CMD_VOLT_LATEST: begin
                  // supply channel latest is already in mV
                  if (!sts.supply) begin
                     cmd.op = OP_VCC_MUL;
                  end
               end
               CMD_RATIO: begin
                  cmd.op   = OP_RAT_MUL;
                  state_in = S_RAT_FOLD;
               end
               default: begin
               end
            endcase
         end
         S_RAT_FOLD: begin
            if (sts.fold_done) begin
               cmd.op   = OP_RAT_TAKE;
               state_in = S_RESP;
            end else begin
               cmd.op = OP_RAT_FOLD;
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.op   = OP_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

### rtl/adc_sample_averager_core.sv
// adc_sample_averager_core: top level of the converter sample averager.
// Depends on asa_pkg, asa_controller, asa_datapath (which holds asa_divider).
`timescale 1ns / 1ps

// Usage
//   req_*  : command transfers (sample, read average/latest, voltage reads,
//            ratiometric read). A transfer happens when req_valid is high and
//            req_stall is low. Sample commands give no result.
//   rsp_*  : one result transfer per read command, taken when rsp_valid is
//            high and rsp_stall is low; the payload holds while stalled.
//   csr_*  : channel_is_supply write, always ready; write only when idle.
// Timing
//   A sample is taken in the idle state and the next command can follow at
//   once. A plain latest read passes the post, scale and response states;
//   an average read first runs the shared divider, two quotient bits per
//   cycle. Supply conversion adds a second division (skipped for a zero
//   divisor), and the ratiometric scale adds a multiply and fold-by-1024
//   steps until the residue is below 1024. The block works on one command
//   at a time and takes the next the cycle after a result is written. A
//   finished result sits in the output register, so the next command is
//   taken while it waits; a stalled receiver only holds the block when a
//   second result is ready to be written.
// Reset (synchronous, active high) clears sum, count, kept average, latest
//   sample, the configuration bit and the output valid.
module adc_sample_averager_core (
   input  logic             clock,
   input  logic             reset,
   // command channel
   input  logic             req_valid,
   output logic             req_stall,
   input  asa_pkg::req_type req_payload,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output asa_pkg::rsp_type rsp_payload,
   // configuration write
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);
   import asa_pkg::*;

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;

   // register write never waits
   assign csr_ready = 1'b1;

   // sequencer: decodes the command and steps the datapath
   asa_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .req_stall   (req_stall),
      .cmd         (ctl_cmd),
      .sts         (ctl_sts)
   );

   // state, multiplier, divider and output register
   asa_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cmd         (ctl_cmd),
      .sts         (ctl_sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
